### rtl/acel_pkg.sv
`timescale 1ns / 1ps

package acel_pkg;

  // Item kinds.
  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_LEN_TICK = 2'd1;
  localparam logic [1:0] OP_ENV_TICK = 2'd2;

  // Register selects for a write.
  localparam logic [1:0] REG_LENGTH     = 2'd0;
  localparam logic [1:0] REG_ENVELOPE   = 2'd1;
  localparam logic [1:0] REG_PERIOD_LOW = 2'd2;
  localparam logic [1:0] REG_CONTROL    = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] reg_select;
    logic [7:0] write_data;
  } in_t;

  typedef struct packed {
    logic        channel_on;
    logic        dac_on;
    logic [3:0]  volume_level;
    logic [10:0] period_value;
  } out_t;

endpackage

### rtl/acel_core.sv
`timescale 1ns / 1ps

module acel_core import acel_pkg::*; #(
  parameter int ENV_PRESCALE    = 8,
  parameter int LENGTH_PRESCALE = 2,
  parameter int LENGTH_LIMIT    = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  in_t  item,
  output out_t result
);

  logic [7:0]  envelope_reg,          envelope_reg_next;
  logic [7:0]  period_low_reg,        period_low_reg_next;
  logic [5:0]  init_length,           init_length_next;
  logic [3:0]  start_volume,          start_volume_next;
  logic [3:0]  volume,                volume_next;
  logic        enabled,               enabled_next;
  logic        dac_enabled,           dac_enabled_next;
  logic        length_enabled,        length_enabled_next;
  logic        env_saturated,         env_saturated_next;
  logic [3:0]  env_prescale_count,    env_prescale_count_next;
  logic [2:0]  pace_count,            pace_count_next;
  logic [1:0]  length_prescale_count, length_prescale_count_next;
  logic [6:0]  length_count,          length_count_next;
  logic [10:0] period,                period_next;

  always_comb begin
    logic [3:0] v;
    logic [2:0] pace;
    logic       up;

    envelope_reg_next          = envelope_reg;
    period_low_reg_next        = period_low_reg;
    init_length_next           = init_length;
    start_volume_next          = start_volume;
    volume_next                = volume;
    enabled_next               = enabled;
    dac_enabled_next           = dac_enabled;
    length_enabled_next        = length_enabled;
    env_saturated_next         = env_saturated;
    env_prescale_count_next    = env_prescale_count;
    pace_count_next            = pace_count;
    length_prescale_count_next = length_prescale_count;
    length_count_next          = length_count;
    period_next                = period;
    v    = volume;
    pace = envelope_reg[2:0];
    up   = envelope_reg[3];

    case (item.op)
      OP_WRITE: begin
        case (item.reg_select)
          REG_LENGTH: init_length_next = item.write_data[5:0];
          REG_ENVELOPE: begin
            // Writing the envelope while the channel runs nudges the volume
            // the way the original hardware does, based on the old settings.
            if (enabled) begin
              if (pace == 3'd0 && !env_saturated) begin
                v = volume + 4'd1;
              end else if (!up) begin
                v = volume + 4'd2;
              end
              if (up != item.write_data[3]) begin
                v = 4'd0 - v;
              end
              volume_next = v;
            end
            envelope_reg_next = item.write_data;
            dac_enabled_next  = |item.write_data[7:3];
            start_volume_next = item.write_data[7:4];
            if (!(|item.write_data[7:3])) begin
              enabled_next = 1'b0;
            end
          end
          REG_PERIOD_LOW: period_low_reg_next = item.write_data;
          default: begin
            period_next         = {item.write_data[2:0], period_low_reg};
            length_enabled_next = item.write_data[6];
            if (item.write_data[7] && dac_enabled) begin
              enabled_next       = 1'b1;
              env_saturated_next = 1'b0;
              pace_count_next    = 3'd0;
              length_count_next  = {1'b0, init_length};
              volume_next        = start_volume;
            end
          end
        endcase
      end
      OP_LEN_TICK: begin
        if (enabled && length_enabled) begin
          length_prescale_count_next = length_prescale_count + 2'd1;
          if (length_prescale_count_next == 2'(LENGTH_PRESCALE)) begin
            length_prescale_count_next = 2'd0;
            length_count_next          = length_count + 7'd1;
            if (length_count_next == 7'(LENGTH_LIMIT)) begin
              length_count_next = 7'd0;
              enabled_next      = 1'b0;
            end
          end
        end
      end
      OP_ENV_TICK: begin
        env_prescale_count_next = env_prescale_count + 4'd1;
        if (env_prescale_count_next == 4'(ENV_PRESCALE)) begin
          env_prescale_count_next = 4'd0;
          if (pace == 3'd0) begin
            pace_count_next = 3'd0;
          end else begin
            pace_count_next = pace_count + 3'd1;
            if (pace_count_next == pace) begin
              pace_count_next = 3'd0;
              if (up && volume != 4'hF) begin
                volume_next = volume + 4'd1;
              end else if (!up && volume != 4'd0) begin
                volume_next = volume - 4'd1;
              end else begin
                env_saturated_next = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      envelope_reg          <= '0;
      period_low_reg        <= '0;
      init_length           <= '0;
      start_volume          <= '0;
      volume                <= '0;
      enabled               <= 1'b0;
      dac_enabled           <= 1'b0;
      length_enabled        <= 1'b0;
      env_saturated         <= 1'b0;
      env_prescale_count    <= '0;
      pace_count            <= '0;
      length_prescale_count <= '0;
      length_count          <= '0;
      period                <= '0;
    end else if (step) begin
      envelope_reg          <= envelope_reg_next;
      period_low_reg        <= period_low_reg_next;
      init_length           <= init_length_next;
      start_volume          <= start_volume_next;
      volume                <= volume_next;
      enabled               <= enabled_next;
      dac_enabled           <= dac_enabled_next;
      length_enabled        <= length_enabled_next;
      env_saturated         <= env_saturated_next;
      env_prescale_count    <= env_prescale_count_next;
      pace_count            <= pace_count_next;
      length_prescale_count <= length_prescale_count_next;
      length_count          <= length_count_next;
      period                <= period_next;
    end
  end

  // The result shows the state after this item.
  assign result.channel_on   = enabled_next;
  assign result.dac_on       = dac_enabled_next;
  assign result.volume_level = volume_next;
  assign result.period_value = period_next;

endmodule

### rtl/acel_out_buf.sv
`timescale 1ns / 1ps

module acel_out_buf import acel_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  out_t push_data,
  output logic space,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic skid_valid;
  out_t skid;
  logic pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid;
        skid     <= push_data;
      end else begin
        out_data <= push_data;
      end
    end else if (push) begin
      if (out_valid) begin
        skid <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

### rtl/audio_channel_envelope_length.sv
`timescale 1ns / 1ps

// Volume envelope and length counter of one sound channel.
// Input beats arrive on in_valid / in_ready / in_data. Each beat is a
// register write (length, envelope, period low, control), a length tick or
// an envelope tick from the frame sequencer. Every input beat produces
// exactly one output beat on out_valid / out_ready / out_data, carrying the
// channel enable, the DAC enable, the current volume and the loaded period
// as they stand after that beat.
// The new state is computed in one short combinational pass from the state
// registers, so the block takes one beat per cycle while in_ready is high,
// and the result is registered into the output buffer on acceptance.
// The results go into a two-entry output buffer (an output register plus a
// skid register). When the receiver stalls, one more input beat is still
// taken; after that in_ready drops until the receiver drains a result.
// Synchronous reset clears all channel state to zero and empties the
// output buffer; the block takes input in the first cycle after reset.
module audio_channel_envelope_length import acel_pkg::*; #(
  parameter int ENV_PRESCALE    = 8,
  parameter int LENGTH_PRESCALE = 2,
  parameter int LENGTH_LIMIT    = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic accept;
  out_t result;

  // A beat is taken whenever the output buffer has a free slot.
  assign accept = in_valid && in_ready;

  acel_core #(
    .ENV_PRESCALE    (ENV_PRESCALE),
    .LENGTH_PRESCALE (LENGTH_PRESCALE),
    .LENGTH_LIMIT    (LENGTH_LIMIT)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (accept),
    .item   (in_data),
    .result (result)
  );

  acel_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/acel_status_checker.sv
`timescale 1ns / 1ps

module acel_status_checker import acel_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   error_count,
  output int   pending
);

  localparam int ENV_PRESCALE    = 8;
  localparam int LENGTH_PRESCALE = 2;
  localparam int LENGTH_LIMIT    = 64;
  localparam int REPORT_LIMIT    = 100;

  // Shadow copy of the channel state.
  logic [7:0]  env_reg;
  logic [7:0]  period_low;
  logic [5:0]  init_len;
  logic [3:0]  start_vol;
  logic [3:0]  vol;
  logic        on;
  logic        dac;
  logic        len_en;
  logic        saturated;
  logic [3:0]  env_prescale;
  logic [2:0]  pace_cnt;
  logic [1:0]  len_prescale;
  logic [6:0]  len_cnt;
  logic [10:0] period;

  out_t expected_status_q[$];
  int   errors = 0;

  function automatic void clear_channel();
    env_reg      = '0;
    period_low   = '0;
    init_len     = '0;
    start_vol    = '0;
    vol          = '0;
    on           = 1'b0;
    dac          = 1'b0;
    len_en       = 1'b0;
    saturated    = 1'b0;
    env_prescale = '0;
    pace_cnt     = '0;
    len_prescale = '0;
    len_cnt      = '0;
    period       = '0;
  endfunction

  function automatic void write_envelope_reg(input logic [7:0] data);
    logic [4:0] v;
    // A running channel gets its volume nudged using the old byte.
    if (on) begin
      v = {1'b0, vol};
      if (env_reg[2:0] == 3'd0 && !saturated)
        v = v + 5'd1;
      else if (!env_reg[3])
        v = v + 5'd2;
      if (env_reg[3] != data[3])
        v = 5'd16 - {1'b0, v[3:0]};
      vol = v[3:0];
    end
    env_reg   = data;
    dac       = (data[7:3] != 5'd0);
    start_vol = data[7:4];
    if (!dac)
      on = 1'b0;
  endfunction

  function automatic void write_control_reg(input logic [7:0] data);
    period = {data[2:0], period_low};
    len_en = data[6];
    if (data[7] && dac) begin
      on        = 1'b1;
      saturated = 1'b0;
      pace_cnt  = '0;
      len_cnt   = {1'b0, init_len};
      vol       = start_vol;
    end
  endfunction

  function automatic void count_length();
    if (on && len_en) begin
      len_prescale = len_prescale + 2'd1;
      if (len_prescale == LENGTH_PRESCALE) begin
        len_prescale = '0;
        len_cnt = len_cnt + 7'd1;
        if (len_cnt == LENGTH_LIMIT) begin
          len_cnt = '0;
          on = 1'b0;
        end
      end
    end
  endfunction

  function automatic void step_envelope();
    env_prescale = env_prescale + 4'd1;
    if (env_prescale == ENV_PRESCALE) begin
      env_prescale = '0;
      if (env_reg[2:0] == 3'd0) begin
        pace_cnt = '0;
      end else begin
        pace_cnt = pace_cnt + 3'd1;
        if (pace_cnt == env_reg[2:0]) begin
          pace_cnt = '0;
          if (env_reg[3] && vol != 4'hF)
            vol = vol + 4'd1;
          else if (!env_reg[3] && vol != 4'd0)
            vol = vol - 4'd1;
          else
            saturated = 1'b1;
        end
      end
    end
  endfunction

  // Applies one input beat to the shadow state and returns the status after it.
  function automatic out_t step_channel(input in_t beat);
    out_t status;
    case (beat.op)
      OP_WRITE: begin
        case (beat.reg_select)
          REG_LENGTH:     init_len = beat.write_data[5:0];
          REG_ENVELOPE:   write_envelope_reg(beat.write_data);
          REG_PERIOD_LOW: period_low = beat.write_data;
          default:        write_control_reg(beat.write_data);
        endcase
      end
      OP_LEN_TICK: count_length();
      OP_ENV_TICK: step_envelope();
      default: ;
    endcase
    status.channel_on   = on;
    status.dac_on       = dac;
    status.volume_level = vol;
    status.period_value = period;
    return status;
  endfunction

  always @(posedge clk) begin : track
    out_t want;
    if (rst) begin
      clear_channel();
      expected_status_q.delete();
    end else begin
      // Retire the output beat first; a result never shares an edge with its input.
      if (out_valid && out_ready) begin
        if (expected_status_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected status beat on=%0b dac=%0b vol=%0d period=%0d",
                     $time, out_data.channel_on, out_data.dac_on,
                     out_data.volume_level, out_data.period_value);
        end else begin
          want = expected_status_q.pop_front();
          if (out_data.channel_on !== want.channel_on || out_data.dac_on !== want.dac_on ||
              out_data.volume_level !== want.volume_level ||
              out_data.period_value !== want.period_value) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("%0t: status mismatch: expected on=%0b dac=%0b vol=%0d period=%0d, %s",
                       $time, want.channel_on, want.dac_on, want.volume_level,
                       want.period_value,
                       $sformatf("got on=%0b dac=%0b vol=%0d period=%0d",
                                 out_data.channel_on, out_data.dac_on,
                                 out_data.volume_level, out_data.period_value));
          end
        end
      end
      if (in_valid && in_ready)
        expected_status_q.push_back(step_channel(in_data));
    end
    error_count <= errors;
    pending     <= expected_status_q.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

// Top of the bench: makes the clock and reset, drives input beats into the
// channel block with bursty idling, stalls the output side on a pattern of
// its own, and gives the verdict. All prediction and comparison is done by
// the status checker that sits beside the block.
module testbench;
  import acel_pkg::*;

  // The op code that the block must ignore while still answering with a beat.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_BEATS = 700;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int error_count;
  int pending;
  int sent = 0;
  int burst_left = 0;
  int cycles = 0;

  audio_channel_envelope_length dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  acel_status_checker status_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .error_count(error_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog. If the run is still going at the limit, something has hung:
  // a lost result or a handshake that never completes.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Output side. The receiver switches at random between three moods:
  // always ready, randomly choppy, and mostly ready with occasional long
  // stalls. The stalls are what fill the block's skid buffer and force
  // in_ready low.
  initial begin : receiver
    int mode;
    int mode_left;
    int stall_left;
    logic ready_next;
    mode = 0;
    mode_left = 0;
    stall_left = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (mode)
        0: ready_next = 1'b1;
        1: ready_next = ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
          end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 12);
            ready_next = 1'b0;
          end else begin
            ready_next = 1'b1;
          end
        end
      endcase
      out_ready <= ready_next;
      @(posedge clk);
    end
  end

  // Sends one beat and returns in the time step of the edge that accepted
  // it. Beats go out in bursts of random length; between bursts the sender
  // usually pauses with valid low, and now and then goes straight on, so
  // there are long stretches with valid held high.
  task automatic send_beat(input logic [1:0] op, input logic [1:0] sel,
                           input logic [7:0] data);
    in_t beat;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    beat.op = op;
    beat.reg_select = sel;
    beat.write_data = data;
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // A tick beat carries random select and data bits, which the block must ignore.
  task automatic send_tick(input logic [1:0] op);
    send_beat(op, 2'($urandom), 8'($urandom));
  endtask

  // Envelope byte for a well-formed setup: mostly a live DAC and short
  // paces so the volume actually moves, sometimes anything at all.
  function automatic logic [7:0] pick_envelope();
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(0, 4) != 0) begin
      if (b[7:3] == 5'd0)
        b[7:4] = 4'($urandom_range(1, 15));
      b[2:0] = ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3));
    end
    return b;
  endfunction

  // One well-formed scenario: set up length, envelope and period, trigger,
  // then run the frame sequencer with a few envelope and control rewrites mixed in so
  // the zombie-mode volume tweak is hit while the channel runs.
  task automatic run_scenario();
    logic [7:0] ctrl;
    int ticks;
    int pick;
    if ($urandom_range(0, 3) != 0)
      send_beat(OP_WRITE, REG_LENGTH, 8'($urandom));
    send_beat(OP_WRITE, REG_ENVELOPE, pick_envelope());
    send_beat(OP_WRITE, REG_PERIOD_LOW, 8'($urandom));
    ctrl = 8'($urandom);
    ctrl[7] = ($urandom_range(0, 7) != 0);
    send_beat(OP_WRITE, REG_CONTROL, ctrl);
    ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(8, 80);
    repeat (ticks) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)
        send_tick(OP_ENV_TICK);
      else if (pick < 90)
        send_tick(OP_LEN_TICK);
      else if (pick < 96)
        send_beat(OP_WRITE, REG_ENVELOPE, 8'($urandom));
      else
        send_beat(OP_WRITE, REG_CONTROL, 8'($urandom));
    end
  endtask

  initial begin : stimulus
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Ticks straight out of reset: the envelope prescaler
    // runs even with the channel off, the length counter must not.
    send_tick(OP_ENV_TICK);
    send_tick(OP_LEN_TICK);
    // The unused op must change nothing but still produce a beat.
    send_beat(OP_UNUSED, REG_CONTROL, 8'hFF);
    // Longest initial length, so two length ticks run it out.
    send_beat(OP_WRITE, REG_LENGTH, 8'hFF);
    send_beat(OP_WRITE, REG_PERIOD_LOW, 8'hFF);
    // Trigger with the DAC off: ignored, but the period is still loaded.
    send_beat(OP_WRITE, REG_CONTROL, 8'h87);
    // Full volume, direction up, zero pace (envelope off), DAC on.
    send_beat(OP_WRITE, REG_ENVELOPE, 8'hF8);
    // Trigger with length enabled, then run the length counter out.
    send_beat(OP_WRITE, REG_CONTROL, 8'hC0);
    send_tick(OP_LEN_TICK);
    send_tick(OP_LEN_TICK);
    // Retrigger, then rewrite the envelope while running: the zombie tweak
    // with a direction change, and a byte that turns the DAC off.
    send_beat(OP_WRITE, REG_CONTROL, 8'h80);
    send_beat(OP_WRITE, REG_ENVELOPE, 8'h07);
    // All-zero envelope byte with the DAC already off.
    send_beat(OP_WRITE, REG_ENVELOPE, 8'h00);
    // Volume 1, down, pace 1: one prescaled period takes it to zero.
    send_beat(OP_WRITE, REG_ENVELOPE, 8'h11);
    send_beat(OP_WRITE, REG_CONTROL, 8'h80);
    repeat (8) send_tick(OP_ENV_TICK);

    // Random part: mostly well-formed scenarios, with some pure noise.
    while (sent < RANDOM_BEATS + 23) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 6))
          send_beat(2'($urandom), 2'($urandom), 8'($urandom));
      else
        run_scenario();
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted beat, then wait on in case the block
    // emits something it should not. The checker's count is registered, so
    // step past the last accepting edge first.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### audio_channel_envelope_length.f
rtl/acel_pkg.sv
rtl/acel_core.sv
rtl/acel_out_buf.sv
rtl/audio_channel_envelope_length.sv
tb/acel_status_checker.sv
tb/testbench.sv
